// File: hdl/assert_macros.svh
// Assertion macros shared by the block's RTL files.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication under synchronous reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hdl/bllca_pkg.sv
// Shared constants, table row layout and port structs of the LCA table.
// No dependencies; used by every module of the block.
package bllca_pkg;

  localparam int NODE_W    = 10;
  localparam int NODES     = 1 << NODE_W;
  localparam int LEVELS    = 10;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int DEPTH_W   = 10;
  localparam int DIST_W    = 11;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [DEPTH_W-1:0] MAX_DEPTH = {DEPTH_W{1'b1}};
  localparam logic [LVL_W-1:0]   LAST_LVL  = LVL_W'(LEVELS - 1);
  localparam logic [NODE_W-1:0]  LAST_NODE = NODE_W'(NODES - 1);

  localparam logic MODE_ATTACH = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // One ancestor entry; "no ancestor" is always stored as all zeros.
  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
  } entry_t;

  typedef entry_t [LEVELS-1:0] anc_row_t;

  // One table row per node: all its power-of-two ancestors and its depth.
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    anc_row_t           anc;
  } row_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    row_t              data;
  } mem_wr_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor_node;
    logic [DIST_W-1:0] tree_distance;
    logic              none_found;
  } result_t;

endpackage

// File: hdl/bllca_store.sv
// Node table: one row per node, one write port, two read ports, registered reads.
// Depends on bllca_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bllca_store (
  input  logic               clk,
  input  logic               rst,
  input  bllca_pkg::mem_rd_t rd_a,
  input  bllca_pkg::mem_rd_t rd_b,
  input  bllca_pkg::mem_wr_t wr,
  output bllca_pkg::row_t    rdata_a,
  output bllca_pkg::row_t    rdata_b
);

  bllca_pkg::row_t mem [bllca_pkg::NODES];

  // Read data holds until the next read on that port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_a.en) begin
      rdata_a <= mem[rd_a.addr];
    end
    if (rd_b.en) begin
      rdata_b <= mem[rd_b.addr];
    end
  end

  `ASSERT_IMPLIES(a_no_rw_overlap, clk, rst, wr.en, !(rd_a.en || rd_b.en))

endmodule

// File: hdl/bllca_outbuf.sv
// Output word register that parts the sequencer from the result stream.
// Depends on bllca_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bllca_outbuf (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  input  bllca_pkg::result_t                     res,
  output logic                                   space,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [bllca_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                   m_axis_tuser
);

  bllca_pkg::result_t held;
  logic               full;

  assign space = !full || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (m_axis_tready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= res;
    end
  end

  assign m_axis_tvalid = full;
  assign m_axis_tdata  = {
    (bllca_pkg::OUT_TDATA_W - bllca_pkg::NODE_W - bllca_pkg::DIST_W)'(0),
    held.tree_distance, held.ancestor_node};
  assign m_axis_tuser  = held.none_found;

  `ASSERT_IMPLIES(a_push_space, clk, rst, push, space)

endmodule

// File: hdl/bllca_ctrl.sv
// Sequencer: clearing pass, attach row build and query walk over the node table.
// Depends on bllca_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bllca_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [bllca_pkg::NODE_W-1:0] node_a,
  input  logic [bllca_pkg::NODE_W-1:0] node_b,
  output bllca_pkg::mem_rd_t           rd_a,
  output bllca_pkg::mem_rd_t           rd_b,
  output bllca_pkg::mem_wr_t           wr,
  input  bllca_pkg::row_t              rdata_a,
  input  bllca_pkg::row_t              rdata_b,
  output logic                         push,
  output bllca_pkg::result_t           res,
  input  logic                         space
);

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_QLOAD  = 11'b000_0000_0100,
    ST_LIFT   = 11'b000_0000_1000,
    ST_CHECK  = 11'b000_0001_0000,
    ST_CLIMB  = 11'b000_0010_0000,
    ST_FINAL  = 11'b000_0100_0000,
    ST_DIST   = 11'b000_1000_0000,
    ST_ASTEP  = 11'b001_0000_0000,
    ST_AWRITE = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_t;

  localparam logic [bllca_pkg::LVL_W-1:0] LVL_W_ONE = bllca_pkg::LVL_W'(1);

  state_t                          state, state_next;
  logic [bllca_pkg::NODE_W-1:0]    clr_cnt;
  logic [bllca_pkg::LVL_W-1:0]     lvl;
  logic [bllca_pkg::LVL_W-1:0]     lvl_prev;
  logic [bllca_pkg::NODE_W-1:0]    a_q, b_q, lca;
  logic [bllca_pkg::DEPTH_W-1:0]   da, db, diff, new_depth;
  bllca_pkg::anc_row_t             built;
  bllca_pkg::entry_t               v, w;
  logic                            in_fire;

  bllca_pkg::entry_t               nv, pv, pw, lw, ap, nb;
  logic                            swap, lift_bit;
  logic [bllca_pkg::NODE_W-1:0]    x_node, y_node;
  logic [bllca_pkg::DEPTH_W-1:0]   dx, dy, depth_inc;
  logic [bllca_pkg::DIST_W-1:0]    dsum, dtwice;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign lvl_prev = lvl - 1'b1;

  always_comb begin
    // query: order the pair so that x is the deeper node
    swap     = rdata_a.depth < rdata_b.depth;
    x_node   = swap ? b_q : a_q;
    y_node   = swap ? a_q : b_q;
    dx       = swap ? rdata_b.depth : rdata_a.depth;
    dy       = swap ? rdata_a.depth : rdata_b.depth;
    lift_bit = diff[lvl];
    nv       = rdata_a.anc[lvl];
    pv       = v.valid ? rdata_a.anc[lvl] : '0;
    pw       = w.valid ? rdata_b.anc[lvl] : '0;
    lw       = w.valid ? rdata_b.anc[0] : '0;
    dsum     = {1'b0, da} + {1'b0, db};
    dtwice   = {rdata_a.depth, 1'b0};
    // attach: forward the row under build when the chain comes back to node_a
    ap       = built[lvl_prev];
    if (!ap.valid) begin
      nb = '0;
    end else if (ap.node == a_q) begin
      nb = ap;
    end else begin
      nb = rdata_a.anc[lvl_prev];
    end
    depth_inc = (rdata_a.depth == bllca_pkg::MAX_DEPTH) ? bllca_pkg::MAX_DEPTH
                                                        : rdata_a.depth + 1'b1;
  end

  always_comb begin
    state_next = state;
    rd_a       = '0;
    rd_b       = '0;
    wr         = '0;
    push       = 1'b0;
    case (state)
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_cnt;
        if (clr_cnt == bllca_pkg::LAST_NODE) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          rd_a.en    = 1'b1;
          rd_a.addr  = (mode == bllca_pkg::MODE_QUERY) ? node_a : node_b;
          rd_b.en    = (mode == bllca_pkg::MODE_QUERY);
          rd_b.addr  = node_b;
          state_next = (mode == bllca_pkg::MODE_QUERY) ? ST_QLOAD : ST_ASTEP;
        end
      end
      ST_QLOAD: begin
        rd_a.en    = 1'b1;
        rd_a.addr  = x_node;
        rd_b.en    = 1'b1;
        rd_b.addr  = y_node;
        state_next = ST_LIFT;
      end
      ST_LIFT: begin
        if (lift_bit && !nv.valid) begin
          state_next = ST_DONE;
        end else begin
          rd_a.en   = lift_bit;
          rd_a.addr = nv.node;
          if (lvl == '0) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        state_next = (v == w) ? ST_DIST : ST_CLIMB;
      end
      ST_CLIMB: begin
        if (pv != pw) begin
          rd_a.en   = 1'b1;
          rd_a.addr = pv.node;
          rd_b.en   = 1'b1;
          rd_b.addr = pw.node;
        end
        if (lvl == '0) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (lw.valid) begin
          rd_a.en    = 1'b1;
          rd_a.addr  = lw.node;
          state_next = ST_DIST;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIST: begin
        state_next = ST_DONE;
      end
      ST_ASTEP: begin
        rd_a.en   = 1'b1;
        rd_a.addr = nb.node;
        if (lvl == bllca_pkg::LAST_LVL) begin
          state_next = ST_AWRITE;
        end
      end
      ST_AWRITE: begin
        wr.en         = 1'b1;
        wr.addr       = a_q;
        wr.data.depth = new_depth;
        wr.data.anc   = built;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (space) begin
          push       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        a_q      <= node_a;
        b_q      <= node_b;
        lvl      <= LVL_W_ONE;
        built[0] <= '{valid: 1'b1, node: node_b};
        res      <= '0;
      end
      ST_QLOAD: begin
        da   <= rdata_a.depth;
        db   <= rdata_b.depth;
        diff <= dx - dy;
        v    <= '{valid: 1'b1, node: x_node};
        w    <= '{valid: 1'b1, node: y_node};
        lvl  <= bllca_pkg::LAST_LVL;
      end
      ST_LIFT: begin
        if (lift_bit && !nv.valid) begin
          res <= '{ancestor_node: '0, tree_distance: '0, none_found: 1'b1};
        end else if (lift_bit) begin
          v <= nv;
        end
        lvl <= lvl_prev;
      end
      ST_CHECK: begin
        lca <= v.node;
        lvl <= bllca_pkg::LAST_LVL;
      end
      ST_CLIMB: begin
        if (pv != pw) begin
          v <= pv;
          w <= pw;
        end
        lvl <= lvl_prev;
      end
      ST_FINAL: begin
        lca <= lw.node;
        if (!lw.valid) begin
          res <= '{ancestor_node: '0, tree_distance: '0, none_found: 1'b1};
        end
      end
      ST_DIST: begin
        res.ancestor_node <= lca;
        res.tree_distance <= (dsum >= dtwice) ? dsum - dtwice : '0;
        res.none_found    <= 1'b0;
      end
      ST_ASTEP: begin
        built[lvl] <= nb;
        if (lvl == LVL_W_ONE) begin
          new_depth <= depth_inc;
        end
        lvl <= lvl + 1'b1;
      end
      default: begin
      end
    endcase
  end

  `ASSERT_IMPLIES(a_wr_state, clk, rst, wr.en, (state == ST_CLEAR) || (state == ST_AWRITE))
  `ASSERT_NEXT(a_attach_seq, clk, rst, in_fire && (mode == bllca_pkg::MODE_ATTACH), state == ST_ASTEP)
  `ASSERT_NEXT(a_dist_done, clk, rst, state == ST_DIST, (state == ST_DONE) && !res.none_found)

endmodule

// File: hdl/binary_lifting_lca_table_top.sv
// The block works on one input word at a time: s_axis_tready is low from accept
// until the result word has gone to the output register.
// Reset: rst (synchronous, active high) starts a clearing pass over all 1024 table
// rows, one row a cycle; s_axis_tready stays low until it is done.
// Top level of the binary-lifting LCA table: stream ports and module wiring.
// Depends on bllca_pkg, bllca_ctrl, bllca_store and bllca_outbuf.

module binary_lifting_lca_table_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: node_a [9:0], node_b [19:10], zero padding [23:20]
  input  logic [bllca_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: mode [0] (0 attach, 1 query)
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: ancestor_node [9:0], tree_distance [20:10], zero padding [23:21]
  output logic [bllca_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // tuser: none_found [0]
  output logic                                 m_axis_tuser
);

  bllca_pkg::mem_rd_t rd_a, rd_b;
  bllca_pkg::mem_wr_t wr;
  bllca_pkg::row_t    rdata_a, rdata_b;
  bllca_pkg::result_t res;
  logic               push, space;

  // Sequencer: owns the table ports and hands each finished word to the output
  // register; it takes the next word as soon as that hand-over is done.
  bllca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .mode     (s_axis_tuser),
    .node_a   (s_axis_tdata[bllca_pkg::NODE_W-1:0]),
    .node_b   (s_axis_tdata[2*bllca_pkg::NODE_W-1:bllca_pkg::NODE_W]),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .wr       (wr),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .push     (push),
    .res      (res),
    .space    (space)
  );

  // Table of ancestor rows and depths, one row per node.
  bllca_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_a    (rd_a),
    .rd_b    (rd_b),
    .wr      (wr),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Hold the result word until the downstream side takes it.
  bllca_outbuf u_outbuf (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .res           (res),
    .space         (space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
